/* rtl/scb_pkg.sv */
// Shared types, constants and a helper function for the sphere collision bounce block.
package scb_pkg;

  // Field widths of the Q16.16 interface.
  localparam int CoordW    = 32;
  localparam int RadW      = 31;
  // Normalized magnitude width: the largest component lands in [2^29, 2^30).
  localparam int MagW      = 30;
  localparam int NormLead  = 29;
  // Sum of squares, square root and normal widths.
  localparam int SqW       = 64;
  localparam int LenW      = 31;
  localparam int NrmW      = 31;
  localparam int KW        = 33;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;
  // Wide signed width used before saturation.
  localparam int WideW     = 38;

  // Reciprocal of ten for a 32-bit dividend: x / 10 = (x * Recip10) >> 35.
  localparam logic [31:0] Recip10     = 32'hCCCC_CCCD;
  localparam int          Recip10Sh   = 35;
  localparam logic [RadW-1:0] SphereRadiusReset = 31'd65536;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegCenterX      = 2'd0,
    RegCenterY      = 2'd1,
    RegCenterZ      = 2'd2,
    RegSphereRadius = 2'd3
  } cfg_reg_e;

  // Per-item values that travel along the long root and divide stages.
  typedef struct packed {
    logic [2:0][CoordW-1:0] vel;
    logic [2:0]             neg;
    logic [2:0][MagW-1:0]   mag;
    logic [KW-1:0]          k;
    logic                   deg;
  } carry_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [CoordW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic [CoordW-1:0] res;
    if (v > $signed({{(WideW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}})) begin
      res = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < $signed({{(WideW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}})) begin
      res = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      res = v[CoordW-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/sphere_collision_bounce.sv */
// Path of a transaction: stages 1-3, square root, divide, post stages 1-4, output register.
// One transaction per cycle if not stalled; 32-step root and 31-step divide are fully pipelined.
// The whole pipeline advances together whenever the output register is empty or being taken.
// Reset clears all stage valid bits and sets the center to zero and the sphere radius to 1.0.
// No clearing pass is needed; the block accepts transactions right after reset.
module sphere_collision_bounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [scb_pkg::CoordW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [scb_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [scb_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [scb_pkg::CoordW-1:0] pos_z_i,
  input  logic signed [scb_pkg::CoordW-1:0] vel_x_i,
  input  logic signed [scb_pkg::CoordW-1:0] vel_y_i,
  input  logic signed [scb_pkg::CoordW-1:0] vel_z_i,
  input  logic [scb_pkg::RadW-1:0]    probe_radius_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [scb_pkg::CoordW-1:0] out_pos_x_o,
  output logic signed [scb_pkg::CoordW-1:0] out_pos_y_o,
  output logic signed [scb_pkg::CoordW-1:0] out_pos_z_o,
  output logic signed [scb_pkg::CoordW-1:0] out_vel_x_o,
  output logic signed [scb_pkg::CoordW-1:0] out_vel_y_o,
  output logic signed [scb_pkg::CoordW-1:0] out_vel_z_o,
  output logic                        degenerate_o
);
  import scb_pkg::*;

  // Global pipeline enable.
  logic en;

  // Configuration registers.
  logic [2:0][CoordW-1:0] center_q;
  logic [RadW-1:0]        sradius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= '0;
      sradius_q <= SphereRadiusReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegCenterX:      center_q[0] <= cfg_data_i;
        RegCenterY:      center_q[1] <= cfg_data_i;
        RegCenterZ:      center_q[2] <= cfg_data_i;
        RegSphereRadius: sradius_q   <= cfg_data_i[RadW-1:0];
        default:         sradius_q   <= sradius_q;
      endcase
    end
  end

  // Stage 1: offset from the center, split into sign and magnitude.
  logic [2:0][CoordW-1:0] in_pos, in_vel;
  logic [2:0][CoordW-1:0] s1_mag_d;
  logic [2:0]             s1_neg_d;
  logic                   s1_valid_q;
  logic [2:0][CoordW-1:0] s1_mag_q, s1_vel_q;
  logic [2:0]             s1_neg_q;
  logic [RadW-1:0]        s1_r_q;
  logic [31:0]            s1_rp5_q;

  assign in_pos = {pos_z_i, pos_y_i, pos_x_i};
  assign in_vel = {vel_z_i, vel_y_i, vel_x_i};

  always_comb begin
    logic [CoordW:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = {in_pos[i][CoordW-1], in_pos[i]} - {center_q[i][CoordW-1], center_q[i]};
      s1_neg_d[i] = diff[CoordW];
      s1_mag_d[i] = diff[CoordW] ? (~diff[CoordW-1:0] + 1'b1) : diff[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mag_q <= s1_mag_d;
      s1_neg_q <= s1_neg_d;
      s1_vel_q <= in_vel;
      s1_r_q   <= probe_radius_i;
      s1_rp5_q <= {1'b0, probe_radius_i} + 32'd5;
    end
  end

  // Stage 2: scale all magnitudes by one power of two; multiply for the tenth.
  logic [4:0]             lead;
  logic [CoordW-1:0]      ormag;
  logic [2:0][MagW-1:0]   s2_mag_d;
  logic                   s2_valid_q, s2_deg_q;
  logic [2:0][MagW-1:0]   s2_mag_q;
  logic [2:0]             s2_neg_q;
  logic [2:0][CoordW-1:0] s2_vel_q;
  logic [RadW-1:0]        s2_r_q;
  logic [63:0]            s2_tp_q;

  always_comb begin
    logic [CoordW-1:0] sh;
    ormag = s1_mag_q[0] | s1_mag_q[1] | s1_mag_q[2];
    lead  = '0;
    for (int b = 0; b < CoordW; b++) begin
      if (ormag[b]) lead = b[4:0];
    end
    for (int i = 0; i < 3; i++) begin
      if (lead > 5'(NormLead)) begin
        sh = s1_mag_q[i] >> (lead - 5'(NormLead));
      end else begin
        sh = s1_mag_q[i] << (5'(NormLead) - lead);
      end
      s2_mag_d[i] = sh[MagW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_mag_q <= s2_mag_d;
      s2_deg_q <= (ormag == '0);
      s2_neg_q <= s1_neg_q;
      s2_vel_q <= s1_vel_q;
      s2_r_q   <= s1_r_q;
      s2_tp_q  <= s1_rp5_q * Recip10;
    end
  end

  // Stage 3: squares of the scaled magnitudes; total push-out distance.
  logic          s3_valid_q;
  logic [2:0][2*MagW-1:0] s3_sq_q;
  carry_t        s3_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_sq_q[i] <= s2_mag_q[i] * s2_mag_q[i];
      end
      s3_c_q.vel <= s2_vel_q;
      s3_c_q.neg <= s2_neg_q;
      s3_c_q.mag <= s2_mag_q;
      s3_c_q.deg <= s2_deg_q;
      s3_c_q.k   <= KW'(sradius_q) + KW'(s2_r_q) + KW'(s2_tp_q[63:Recip10Sh]);
    end
  end

  // Square root pipeline: entry 0 holds the sum of squares, one result bit per stage.
  logic               sq_valid_q [SqrtSteps+1];
  logic [SqW-1:0]     sq_x_q     [SqrtSteps+1];
  logic [SqW-1:0]     sq_r_q     [SqrtSteps+1];
  carry_t             sq_c_q     [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q[0] <= 1'b0;
    end else if (en) begin
      sq_valid_q[0] <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_x_q[0] <= SqW'(s3_sq_q[0]) + SqW'(s3_sq_q[1]) + SqW'(s3_sq_q[2]);
      sq_r_q[0] <= '0;
      sq_c_q[0] <= s3_c_q;
    end
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam logic [SqW-1:0] Bit = SqW'(1) << (62 - 2 * j);
    logic [SqW-1:0] trial, x_d, r_d;

    // Restoring square-root step.
    always_comb begin
      trial = sq_r_q[j] + Bit;
      if (sq_x_q[j] >= trial) begin
        x_d = sq_x_q[j] - trial;
        r_d = (sq_r_q[j] >> 1) + Bit;
      end else begin
        x_d = sq_x_q[j];
        r_d = sq_r_q[j] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[j+1] <= 1'b0;
      end else if (en) begin
        sq_valid_q[j+1] <= sq_valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_x_q[j+1] <= x_d;
        sq_r_q[j+1] <= r_d;
        sq_c_q[j+1] <= sq_c_q[j];
      end
    end
  end

  // Divide pipeline: normal magnitude = mag * 2^30 / length, one quotient bit per stage.
  logic                   dv_valid_q [DivSteps];
  logic [LenW-1:0]        dv_len_q   [DivSteps];
  logic [2:0][LenW-1:0]   dv_rem_q   [DivSteps];
  logic [2:0][NrmW-1:0]   dv_quo_q   [DivSteps];
  carry_t                 dv_c_q     [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic                 src_valid;
    logic [LenW-1:0]      src_len;
    logic [2:0][LenW:0]   src_cand;
    logic [2:0][NrmW-1:0] src_quo;
    carry_t               src_c;
    logic [2:0][LenW-1:0] rem_d;
    logic [2:0][NrmW-1:0] quo_d;

    if (j == 0) begin : g_first
      assign src_valid = sq_valid_q[SqrtSteps];
      assign src_len   = sq_r_q[SqrtSteps][LenW-1:0];
      assign src_c     = sq_c_q[SqrtSteps];
      assign src_quo   = '0;
      for (genvar i = 0; i < 3; i++) begin : g_ax
        assign src_cand[i] = (LenW+1)'(sq_c_q[SqrtSteps].mag[i]);
      end
    end else begin : g_next
      assign src_valid = dv_valid_q[j-1];
      assign src_len   = dv_len_q[j-1];
      assign src_c     = dv_c_q[j-1];
      assign src_quo   = dv_quo_q[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_ax
        assign src_cand[i] = {dv_rem_q[j-1][i], 1'b0};
      end
    end

    // Restoring division step for each axis.
    always_comb begin
      logic [LenW:0] diff;
      for (int i = 0; i < 3; i++) begin
        diff = src_cand[i] - {1'b0, src_len};
        if (src_cand[i] >= {1'b0, src_len}) begin
          rem_d[i] = diff[LenW-1:0];
          quo_d[i] = {src_quo[i][NrmW-2:0], 1'b1};
        end else begin
          rem_d[i] = src_cand[i][LenW-1:0];
          quo_d[i] = {src_quo[i][NrmW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j] <= 1'b0;
      end else if (en) begin
        dv_valid_q[j] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_len_q[j] <= src_len;
        dv_rem_q[j] <= rem_d;
        dv_quo_q[j] <= quo_d;
        dv_c_q[j]   <= src_c;
      end
    end
  end

  // Post stage 1: velocity times normal, and distance times normal.
  logic [2:0][NrmW-1:0]   nq;
  logic                   p1_valid_q, p1_deg_q;
  logic [2:0][63:0]       p1_vn_q, p1_kn_q;
  logic [2:0][NrmW-1:0]   p1_nq_q;
  logic [2:0]             p1_neg_q;
  logic [2:0][CoordW-1:0] p1_vel_q;

  assign nq = dv_quo_q[DivSteps-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= dv_valid_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [CoordW-1:0] nsig;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nsig = dv_c_q[DivSteps-1].neg[i] ? -$signed({1'b0, nq[i]}) : $signed({1'b0, nq[i]});
        p1_vn_q[i] <= 64'($signed(dv_c_q[DivSteps-1].vel[i])) * 64'(nsig);
        p1_kn_q[i] <= 64'(dv_c_q[DivSteps-1].k) * 64'(nq[i]);
      end
      p1_nq_q  <= nq;
      p1_neg_q <= dv_c_q[DivSteps-1].neg;
      p1_vel_q <= dv_c_q[DivSteps-1].vel;
      p1_deg_q <= dv_c_q[DivSteps-1].deg;
    end
  end

  // Post stage 2: dot product sum and the pushed-out position.
  logic                   p2_valid_q, p2_deg_q;
  logic signed [65:0]     p2_dot_q;
  logic [2:0][CoordW-1:0] p2_pos_q, p2_vel_q;
  logic [2:0][NrmW-1:0]   p2_nq_q;
  logic [2:0]             p2_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [63:0]             off;
    logic signed [WideW-1:0] pw;
    if (en) begin
      p2_dot_q <= 66'($signed(p1_vn_q[0])) + 66'($signed(p1_vn_q[1]))
                + 66'($signed(p1_vn_q[2]));
      for (int i = 0; i < 3; i++) begin
        off = (p1_kn_q[i] + 64'(1 << 29)) >> 30;
        pw  = WideW'($signed(center_q[i]));
        if (p1_neg_q[i]) begin
          pw = pw - $signed(WideW'(off));
        end else begin
          pw = pw + $signed(WideW'(off));
        end
        p2_pos_q[i] <= p1_deg_q ? center_q[i] : sat32(pw);
      end
      p2_vel_q <= p1_vel_q;
      p2_nq_q  <= p1_nq_q;
      p2_neg_q <= p1_neg_q;
      p2_deg_q <= p1_deg_q;
    end
  end

  // Post stage 3: round the dot product to Q16.16 as sign and magnitude.
  logic                   p3_valid_q, p3_deg_q, p3_dneg_q;
  logic [33:0]            p3_dmag_q;
  logic [2:0][CoordW-1:0] p3_pos_q, p3_vel_q;
  logic [2:0][NrmW-1:0]   p3_nq_q;
  logic [2:0]             p3_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [65:0] amag, rnd;
    if (en) begin
      amag = p2_dot_q[65] ? 66'(-p2_dot_q) : 66'(p2_dot_q);
      rnd  = (amag + 66'(1 << 29)) >> 30;
      p3_dmag_q <= rnd[33:0];
      p3_dneg_q <= p2_dot_q[65];
      p3_pos_q  <= p2_pos_q;
      p3_vel_q  <= p2_vel_q;
      p3_nq_q   <= p2_nq_q;
      p3_neg_q  <= p2_neg_q;
      p3_deg_q  <= p2_deg_q;
    end
  end

  // Post stage 4: twice the projection along each axis, unscaled.
  logic                   p4_valid_q, p4_deg_q;
  logic [2:0][64:0]       p4_tn_q;
  logic [2:0]             p4_tneg_q;
  logic [2:0][CoordW-1:0] p4_pos_q, p4_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else if (en) begin
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p4_tn_q[i]   <= 65'(p3_dmag_q) * 65'(p3_nq_q[i]);
        p4_tneg_q[i] <= p3_dneg_q ^ p3_neg_q[i];
      end
      p4_pos_q <= p3_pos_q;
      p4_vel_q <= p3_vel_q;
      p4_deg_q <= p3_deg_q;
    end
  end

  // Output register: reflected velocity, saturated.
  logic                   out_valid_q, out_deg_q;
  logic [2:0][CoordW-1:0] out_pos_q, out_vel_q;

  assign en = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [64:0]             term;
    logic signed [WideW-1:0] vw;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        term = (p4_tn_q[i] + 65'(1 << 28)) >> 29;
        vw   = WideW'($signed(p4_vel_q[i]));
        if (p4_tneg_q[i]) begin
          vw = vw + $signed(WideW'(term));
        end else begin
          vw = vw - $signed(WideW'(term));
        end
        out_vel_q[i] <= p4_deg_q ? p4_vel_q[i] : sat32(vw);
      end
      out_pos_q <= p4_pos_q;
      out_deg_q <= p4_deg_q;
    end
  end

  assign in_ready_o   = en;
  assign out_valid_o  = out_valid_q;
  assign out_pos_x_o  = out_pos_q[0];
  assign out_pos_y_o  = out_pos_q[1];
  assign out_pos_z_o  = out_pos_q[2];
  assign out_vel_x_o  = out_vel_q[0];
  assign out_vel_y_o  = out_vel_q[1];
  assign out_vel_z_o  = out_vel_q[2];
  assign degenerate_o = out_deg_q;

endmodule

/* rtl/scb_chk.sv */
// Port-level checker for the sphere collision bounce block, with its bind statement.
module scb_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [scb_pkg::CoordW-1:0]  out_pos_x_o,
  input logic [scb_pkg::CoordW-1:0]  out_pos_y_o,
  input logic [scb_pkg::CoordW-1:0]  out_pos_z_o,
  input logic [scb_pkg::CoordW-1:0]  out_vel_x_o,
  input logic [scb_pkg::CoordW-1:0]  out_vel_y_o,
  input logic [scb_pkg::CoordW-1:0]  out_vel_z_o,
  input logic                        degenerate_o
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The pipeline moves only when the output register can drain.
  a_ready_tracks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  // A stalled pipeline freezes the result payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({out_pos_x_o, out_pos_y_o, out_pos_z_o,
                                             out_vel_x_o, out_vel_y_o, out_vel_z_o,
                                             degenerate_o}))
    else $error("result payload changed while stalled");

  // Nothing is offered while reset is held.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

endmodule

bind sphere_collision_bounce scb_chk u_scb_chk (.*);

/* tb/sv/sphere_collision_bounce_check.sv */
// Checker for the sphere collision bounce block: it predicts each result and compares it.
module sphere_collision_bounce_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [30:0] probe_radius_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_pos_x_i,
  input  logic [31:0] out_pos_y_i,
  input  logic [31:0] out_pos_z_i,
  input  logic [31:0] out_vel_x_i,
  input  logic [31:0] out_vel_y_i,
  input  logic [31:0] out_vel_z_i,
  input  logic        degenerate_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          bounce_count_o
);
  import scb_pkg::*;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic        deg;
  } bounce_t;

  bounce_t bounce_q[$];
  logic signed [63:0] ctr [3];
  longint unsigned    sph_rad;

  function automatic longint unsigned magnitude(longint signed x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint signed with_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Product of magnitudes, rounded half away from zero after the shift.
  function automatic longint signed mul_rnd(longint signed a, longint signed b, int sh);
    longint unsigned m;
    m = magnitude(a) * magnitude(b);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return with_sign(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint signed v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Normal, push-out distance and reflection for one transaction.
  function automatic bounce_t bounce(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                     logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                     logic [30:0] rad);
    bounce_t res;
    longint signed p [3];
    longint signed v [3];
    longint signed d [3];
    longint signed nrm [3];
    longint unsigned a [3];
    longint unsigned mx, s, len, k;
    longint signed dot, dot_q;
    logic [31:0] op [3];
    logic [31:0] ov [3];
    p[0] = longint'($signed(px)); p[1] = longint'($signed(py)); p[2] = longint'($signed(pz));
    v[0] = longint'($signed(vx)); v[1] = longint'($signed(vy)); v[2] = longint'($signed(vz));
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = p[i] - ctr[i];
      a[i] = magnitude(d[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      // Point sits on the center: no normal, velocity passes through.
      for (int i = 0; i < 3; i++) begin
        op[i] = clamp32(ctr[i]);
        ov[i] = clamp32(v[i]);
      end
      res.deg = 1'b1;
    end else begin
      while (mx >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
        mx = mx >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
        mx = mx << 1;
      end
      s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) nrm[i] = with_sign((a[i] << 30) / len, d[i] < 0);
      k = sph_rad + rad + (longint'(rad) + 5) / 10;
      dot = 0;
      for (int i = 0; i < 3; i++) dot = dot + v[i] * nrm[i];
      dot_q = with_sign((magnitude(dot) + (64'd1 << 29)) >> 30, dot < 0);
      for (int i = 0; i < 3; i++) begin
        op[i] = clamp32(ctr[i] + mul_rnd(longint'(k), nrm[i], 30));
        ov[i] = clamp32(v[i] - mul_rnd(dot_q, nrm[i], 29));
      end
      res.deg = 1'b0;
    end
    res.pos_x = op[0]; res.pos_y = op[1]; res.pos_z = op[2];
    res.vel_x = ov[0]; res.vel_y = ov[1]; res.vel_z = ov[2];
    return res;
  endfunction

  assign pending_o = bounce_q.size();

  // Track the registers, predict on every input transaction, compare on every output one.
  always @(posedge clk_i or negedge rst_ni) begin
    bounce_t got, want;
    if (!rst_ni) begin
      ctr[0] = 0; ctr[1] = 0; ctr[2] = 0;
      sph_rad = 65536;
      fail_count_o = 0;
      bounce_count_o = 0;
      bounce_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {out_pos_x_i, out_pos_y_i, out_pos_z_i, out_vel_x_i, out_vel_y_i, out_vel_z_i,
               degenerate_i};
        bounce_count_o = bounce_count_o + 1;
        if (bounce_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("unexpected output transaction %h", got);
        end else begin
          want = bounce_q.pop_front();
          if (got != want) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10) begin
              $display("mismatch pos exp %h %h %h got %h %h %h", want.pos_x, want.pos_y,
                       want.pos_z, got.pos_x, got.pos_y, got.pos_z);
              $display("         vel exp %h %h %h got %h %h %h, deg exp %b got %b",
                       want.vel_x, want.vel_y, want.vel_z, got.vel_x, got.vel_y, got.vel_z,
                       want.deg, got.deg);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        bounce_q.push_back(bounce(pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i,
                                  probe_radius_i));
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegCenterX:      ctr[0] = longint'($signed(cfg_data_i));
          RegCenterY:      ctr[1] = longint'($signed(cfg_data_i));
          RegCenterZ:      ctr[2] = longint'($signed(cfg_data_i));
          RegSphereRadius: sph_rad = longint'(cfg_data_i[30:0]);
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/sv/sphere_collision_bounce_test.sv */
// Stimulus and verdict for the sphere collision bounce block.
module sphere_collision_bounce_test;
  import scb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [30:0] probe_radius_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic [31:0] out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic        degenerate_o;
  int          fail_count, pending, bounce_count;
  bit          no_idle = 1'b0;
  int          sent = 0;
  logic [31:0] cur_ctr [3];

  sphere_collision_bounce uut (.*);

  sphere_collision_bounce_check checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .pos_x_i, .pos_y_i, .pos_z_i, .vel_x_i, .vel_y_i, .vel_z_i, .probe_radius_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .out_pos_x_i(out_pos_x_o), .out_pos_y_i(out_pos_y_o), .out_pos_z_i(out_pos_z_o),
    .out_vel_x_i(out_vel_x_o), .out_vel_y_i(out_vel_y_o), .out_vel_z_i(out_vel_z_o),
    .degenerate_i(degenerate_o),
    .fail_count_o(fail_count), .pending_o(pending), .bounce_count_o(bounce_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The receiver stalls now and then unless idling is switched off.
  always @(negedge clk_i) out_ready_i = no_idle || ($urandom_range(0, 99) >= 8);

  // Stop offering input, wait for every result, then let the pipeline run dry.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    if (idx != RegSphereRadius) cur_ctr[idx] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [30:0] rad);
    drain();
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegCenterZ, cz);
    write_reg(RegSphereRadius, {1'b0, rad});
  endtask

  // Present one transaction and hold it until it is taken; called at a falling edge.
  task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [30:0] rad);
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pos_x_i = px; pos_y_i = py; pos_z_i = pz;
    vel_x_i = vx; vel_y_i = vy; vel_z_i = vz;
    probe_radius_i = rad;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  // One coordinate: wide random, near the center, on the center, or at an extreme.
  function automatic logic [31:0] pick_coord(logic [31:0] c);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return c + $urandom_range(0, 2 << 20) - (1 << 20);
      7, 8:       return c;
      default:    return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_vel();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 1 << 22) - (1 << 21);
  endfunction

  task automatic send_random(int count);
    logic [31:0] px, py, pz;
    logic [30:0] rad;
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) begin
        px = cur_ctr[0]; py = cur_ctr[1]; pz = cur_ctr[2];
      end else begin
        px = pick_coord(cur_ctr[0]); py = pick_coord(cur_ctr[1]); pz = pick_coord(cur_ctr[2]);
      end
      rad = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
      send(px, py, pz, pick_vel(), pick_vel(), pick_vel(), rad);
    end
  endtask

  initial begin
    cur_ctr[0] = '0; cur_ctr[1] = '0; cur_ctr[2] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, on-center point, axes, extremes and saturation.
    send(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 31'd0);
    send(32'h0001_0000, 32'h0, 32'h0, 32'hffff_0000, 32'h0, 32'h0, 31'd65536);
    send(32'h0, 32'hffff_0000, 32'h0, 32'h0, 32'h0003_0000, 32'h0, 31'd5);
    send(32'h0, 32'h0, 32'h0000_0001, 32'h1234_5678, 32'h0, 32'hffff_ffff, 31'd4);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
         32'h7fff_ffff, 31'h7fff_ffff);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 31'h7fff_ffff);
    send(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 31'd15);
    send(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
         32'hfffd_0000, 31'd655360);
    setup(32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'h7fff_ffff);
    send(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0000_0100, 32'h0, 32'h0, 31'd0);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'h7fff_ffff);
    send(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'd1);
    setup(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 31'd0);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 31'd0);
    send(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 31'd9);
    send(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
         32'h0, 31'd3);

    // Random phases over several settings, extremes among them.
    setup(32'h0, 32'h0, 32'h0, 31'd65536);
    send_random(100);
    drain();
    no_idle = 1'b1;
    send_random(80);
    no_idle = 1'b0;
    setup($urandom, $urandom, $urandom, 31'($urandom));
    send_random(90);
    setup(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_random(80);
    setup(32'h0010_0000, 32'hfff0_0000, 32'h0, 31'd0);
    send_random(80);
    setup($urandom, $urandom, $urandom, 31'($urandom_range(0, 1 << 24)));
    send_random(80);
    in_valid_i = 1'b0;

    drain();
    $display("Run covered %0d input transactions and %0d results over several register settings,",
             sent, bounce_count);
    $display("including on-center points, saturating extremes and random stalls on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("sphere_collision_bounce verification clean");
    end else begin
      $display("sphere_collision_bounce verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("sphere_collision_bounce verification failed");
    $finish;
  end
endmodule
